[src/rsp_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package rsp_pkg;

  localparam int unsigned COORD_WIDTH_DEF = 16;

  // Positions of the left, top, right and bottom edges within a packed rectangle.
  localparam int unsigned EDGE_L = 0;
  localparam int unsigned EDGE_T = 1;
  localparam int unsigned EDGE_R = 2;
  localparam int unsigned EDGE_B = 3;

  // Piece slots in emission order.
  localparam int unsigned NUM_PIECES = 4;
  localparam int unsigned SLOT_ABOVE = 0;
  localparam int unsigned SLOT_BELOW = 1;
  localparam int unsigned SLOT_LEFT  = 2;
  localparam int unsigned SLOT_RIGHT = 3;

  typedef logic [NUM_PIECES-1:0] piece_mask_t;

  // Result of comparing the normalised source against the normalised cut.
  typedef struct packed {
    logic overlap;
    logic above;
    logic below;
    logic left;
    logic right;
  } cut_flags_t;

endpackage

`default_nettype wire

[src/rsp_norm.sv]
`timescale 1ns / 1ps
`default_nettype none

module rsp_norm #(
  parameter int unsigned COORD_WIDTH = 16
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        up_valid,
  output logic                             up_ready,
  input  wire logic [3:0][COORD_WIDTH-1:0] up_src,
  input  wire logic [3:0][COORD_WIDTH-1:0] up_cut,
  output logic                             dn_valid,
  input  wire logic                        dn_ready,
  output logic      [3:0][COORD_WIDTH-1:0] dn_src,
  output logic      [3:0][COORD_WIDTH-1:0] dn_cut
);
  import rsp_pkg::*;

  logic                        valid_r;
  logic [3:0][COORD_WIDTH-1:0] src_r, src_nxt;
  logic [3:0][COORD_WIDTH-1:0] cut_r, cut_nxt;

  // Swap any reversed pair so that left <= right and top <= bottom.
  always_comb begin
    src_nxt = up_src;
    cut_nxt = up_cut;
    if ($signed(up_src[EDGE_L]) > $signed(up_src[EDGE_R])) begin
      src_nxt[EDGE_L] = up_src[EDGE_R];
      src_nxt[EDGE_R] = up_src[EDGE_L];
    end
    if ($signed(up_src[EDGE_T]) > $signed(up_src[EDGE_B])) begin
      src_nxt[EDGE_T] = up_src[EDGE_B];
      src_nxt[EDGE_B] = up_src[EDGE_T];
    end
    if ($signed(up_cut[EDGE_L]) > $signed(up_cut[EDGE_R])) begin
      cut_nxt[EDGE_L] = up_cut[EDGE_R];
      cut_nxt[EDGE_R] = up_cut[EDGE_L];
    end
    if ($signed(up_cut[EDGE_T]) > $signed(up_cut[EDGE_B])) begin
      cut_nxt[EDGE_T] = up_cut[EDGE_B];
      cut_nxt[EDGE_B] = up_cut[EDGE_T];
    end
  end

  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      src_r <= src_nxt;
      cut_r <= cut_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_src   = src_r;
  assign dn_cut   = cut_r;

endmodule

`default_nettype wire

[src/rsp_classify.sv]
`timescale 1ns / 1ps
`default_nettype none

module rsp_classify #(
  parameter int unsigned COORD_WIDTH = 16
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        up_valid,
  output logic                             up_ready,
  input  wire logic [3:0][COORD_WIDTH-1:0] up_src,
  input  wire logic [3:0][COORD_WIDTH-1:0] up_cut,
  output logic                             dn_valid,
  input  wire logic                        dn_ready,
  output logic      [3:0][COORD_WIDTH-1:0] dn_src,
  output logic      [3:0][COORD_WIDTH-1:0] dn_cut,
  output rsp_pkg::cut_flags_t              dn_flags
);
  import rsp_pkg::*;

  logic                        valid_r;
  logic [3:0][COORD_WIDTH-1:0] src_r;
  logic [3:0][COORD_WIDTH-1:0] cut_r;
  cut_flags_t                  flags_r, flags_nxt;
  logic [COORD_WIDTH-1:0]      isect_l, isect_t, isect_r, isect_b;

  always_comb begin
    isect_l = ($signed(up_src[EDGE_L]) > $signed(up_cut[EDGE_L])) ?
              up_src[EDGE_L] : up_cut[EDGE_L];
    isect_t = ($signed(up_src[EDGE_T]) > $signed(up_cut[EDGE_T])) ?
              up_src[EDGE_T] : up_cut[EDGE_T];
    isect_r = ($signed(up_src[EDGE_R]) < $signed(up_cut[EDGE_R])) ?
              up_src[EDGE_R] : up_cut[EDGE_R];
    isect_b = ($signed(up_src[EDGE_B]) < $signed(up_cut[EDGE_B])) ?
              up_src[EDGE_B] : up_cut[EDGE_B];
    flags_nxt.overlap = ($signed(isect_l) <= $signed(isect_r)) &&
                        ($signed(isect_t) <= $signed(isect_b));
    flags_nxt.above   = $signed(up_cut[EDGE_T]) > $signed(up_src[EDGE_T]);
    flags_nxt.below   = $signed(up_cut[EDGE_B]) < $signed(up_src[EDGE_B]);
    flags_nxt.left    = $signed(up_cut[EDGE_L]) > $signed(up_src[EDGE_L]);
    flags_nxt.right   = $signed(up_cut[EDGE_R]) < $signed(up_src[EDGE_R]);
  end

  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      src_r   <= up_src;
      cut_r   <= up_cut;
      flags_r <= flags_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_src   = src_r;
  assign dn_cut   = cut_r;
  assign dn_flags = flags_r;

endmodule

`default_nettype wire

[src/rsp_pieces.sv]
`timescale 1ns / 1ps
`default_nettype none

module rsp_pieces #(
  parameter int unsigned COORD_WIDTH = 16
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             up_valid,
  output logic                                  up_ready,
  input  wire logic      [3:0][COORD_WIDTH-1:0] up_src,
  input  wire logic      [3:0][COORD_WIDTH-1:0] up_cut,
  input  wire rsp_pkg::cut_flags_t              up_flags,
  output logic                                  dn_valid,
  input  wire logic                             dn_ready,
  output logic [3:0][3:0][COORD_WIDTH-1:0]      dn_pieces,
  output rsp_pkg::piece_mask_t                  dn_mask
);
  import rsp_pkg::*;

  localparam logic [COORD_WIDTH-1:0] ONE = COORD_WIDTH'(1);

  logic                             valid_r;
  logic [3:0][3:0][COORD_WIDTH-1:0] pieces_r, pieces_nxt;
  piece_mask_t                      mask_r, mask_nxt;
  logic [COORD_WIDTH-1:0]           strip_t, strip_b;

  always_comb begin
    // The side strips cover only the rows left once the bands are taken off.
    strip_t = up_flags.above ? up_cut[EDGE_T] : up_src[EDGE_T];
    strip_b = up_flags.below ? up_cut[EDGE_B] : up_src[EDGE_B];

    pieces_nxt[SLOT_ABOVE] = up_src;
    pieces_nxt[SLOT_ABOVE][EDGE_B] = up_cut[EDGE_T] - ONE;

    pieces_nxt[SLOT_BELOW] = up_src;
    pieces_nxt[SLOT_BELOW][EDGE_T] = up_cut[EDGE_B] + ONE;

    pieces_nxt[SLOT_LEFT] = up_src;
    pieces_nxt[SLOT_LEFT][EDGE_T] = strip_t;
    pieces_nxt[SLOT_LEFT][EDGE_B] = strip_b;
    pieces_nxt[SLOT_LEFT][EDGE_R] = up_cut[EDGE_L] - ONE;

    pieces_nxt[SLOT_RIGHT] = up_src;
    pieces_nxt[SLOT_RIGHT][EDGE_T] = strip_t;
    pieces_nxt[SLOT_RIGHT][EDGE_B] = strip_b;
    pieces_nxt[SLOT_RIGHT][EDGE_L] = up_cut[EDGE_R] + ONE;

    mask_nxt = '0;
    if (up_flags.overlap) begin
      mask_nxt[SLOT_ABOVE] = up_flags.above;
      mask_nxt[SLOT_BELOW] = up_flags.below;
      mask_nxt[SLOT_LEFT]  = up_flags.left;
      mask_nxt[SLOT_RIGHT] = up_flags.right;
    end else begin
      // Disjoint rectangles: the source passes through as the only piece.
      pieces_nxt[SLOT_ABOVE] = up_src;
      mask_nxt[SLOT_ABOVE]   = 1'b1;
    end
  end

  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      pieces_r <= pieces_nxt;
      mask_r   <= mask_nxt;
    end
  end

  assign dn_valid  = valid_r;
  assign dn_pieces = pieces_r;
  assign dn_mask   = mask_r;

endmodule

`default_nettype wire

[src/rsp_serial.sv]
`timescale 1ns / 1ps
`default_nettype none

module rsp_serial #(
  parameter int unsigned COORD_WIDTH = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              up_valid,
  output logic                                   up_ready,
  input  wire logic [3:0][3:0][COORD_WIDTH-1:0]  up_pieces,
  input  wire rsp_pkg::piece_mask_t              up_mask,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic      [3:0][COORD_WIDTH-1:0]       out_piece,
  output logic      [1:0]                        out_index,
  output logic                                   out_last
);
  import rsp_pkg::*;

  logic [3:0][3:0][COORD_WIDTH-1:0] pieces_r;
  piece_mask_t                      mask_r, mask_nxt, mask_after;
  logic [1:0]                       cnt_r, cnt_nxt;
  logic [1:0]                       sel;
  logic                             out_ld, pop, load;
  logic                             out_valid_r;
  logic [3:0][COORD_WIDTH-1:0]      out_piece_r;
  logic [1:0]                       out_index_r;
  logic                             out_last_r;

  always_comb begin
    priority if (mask_r[0]) begin
      sel = 2'd0;
    end else if (mask_r[1]) begin
      sel = 2'd1;
    end else if (mask_r[2]) begin
      sel = 2'd2;
    end else if (mask_r[3]) begin
      sel = 2'd3;
    end else begin
      sel = 2'd0;
    end
  end

  assign out_ld     = !out_valid_r || !out_stall;
  assign pop        = (|mask_r) && out_ld;
  assign mask_after = pop ? (mask_r & ~(piece_mask_t'(1) << sel)) : mask_r;
  // A new request is taken in the cycle that the current one gives up its
  // last piece, so pieces of consecutive requests follow without a gap.
  assign up_ready   = (mask_after == '0);
  assign load       = up_valid && up_ready;

  always_comb begin
    mask_nxt = load ? up_mask : mask_after;
    cnt_nxt  = cnt_r;
    if (load) begin
      cnt_nxt = 2'd0;
    end else if (pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r      <= '0;
      cnt_r       <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      mask_r <= mask_nxt;
      cnt_r  <= cnt_nxt;
      if (out_ld) begin
        out_valid_r <= pop;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      pieces_r <= up_pieces;
    end
    if (pop) begin
      out_piece_r <= pieces_r[sel];
      out_index_r <= cnt_r;
      out_last_r  <= (mask_after == '0);
    end
  end

  assign out_valid = out_valid_r;
  assign out_piece = out_piece_r;
  assign out_index = out_index_r;
  assign out_last  = out_last_r;

endmodule

`default_nettype wire

[src/rect_subtract_pieces_unit.sv]
// Rectangle difference: source minus cut, emitted as up to four pieces.
//
// Input channel (in_valid / in_stall): one request carries a source and a
// cut rectangle with inclusive signed corners; reversed edges are swapped.
// Output channel (out_valid / out_stall): one piece per transfer, with
// out_piece_index counting from zero and out_piece_last on the final piece.
// A disjoint cut returns the normalised source alone; a fully covered
// source returns nothing at all.
//
// A request passes the normalise, classify and piece-building registers,
// then the serialiser's piece store and its output register, before its
// first piece is shown. The single output register delivers one piece a
// cycle while the receiver does not stall. A request has one to four
// pieces, or none; the serialiser takes the next request only once the
// current one has given up its last piece.
// Reset clears every valid bit and the serialiser's mask and counter; no data register is reset.
// When the receiver stalls, the shown piece holds and the stages fill up
// behind it; in_stall rises only once every stage is occupied.
`timescale 1ns / 1ps
`default_nettype none

module rect_subtract_pieces_unit #(
  parameter int unsigned COORD_WIDTH = rsp_pkg::COORD_WIDTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic signed [COORD_WIDTH-1:0] in_src_left,
  input  wire logic signed [COORD_WIDTH-1:0] in_src_top,
  input  wire logic signed [COORD_WIDTH-1:0] in_src_right,
  input  wire logic signed [COORD_WIDTH-1:0] in_src_bottom,
  input  wire logic signed [COORD_WIDTH-1:0] in_cut_left,
  input  wire logic signed [COORD_WIDTH-1:0] in_cut_top,
  input  wire logic signed [COORD_WIDTH-1:0] in_cut_right,
  input  wire logic signed [COORD_WIDTH-1:0] in_cut_bottom,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic signed      [COORD_WIDTH-1:0] out_piece_left,
  output logic signed      [COORD_WIDTH-1:0] out_piece_top,
  output logic signed      [COORD_WIDTH-1:0] out_piece_right,
  output logic signed      [COORD_WIDTH-1:0] out_piece_bottom,
  output logic             [1:0]             out_piece_index,
  output logic                               out_piece_last
);
  import rsp_pkg::*;

  logic [3:0][COORD_WIDTH-1:0]      in_src, in_cut;
  logic                             s1_ready;
  logic                             s1_valid, s2_ready;
  logic [3:0][COORD_WIDTH-1:0]      s1_src, s1_cut;
  logic                             s2_valid, s3_ready;
  logic [3:0][COORD_WIDTH-1:0]      s2_src, s2_cut;
  cut_flags_t                       s2_flags;
  logic                             s3_valid, ser_ready;
  logic [3:0][3:0][COORD_WIDTH-1:0] s3_pieces;
  piece_mask_t                      s3_mask;
  logic [3:0][COORD_WIDTH-1:0]      out_piece;

  always_comb begin
    in_src[EDGE_L] = in_src_left;
    in_src[EDGE_T] = in_src_top;
    in_src[EDGE_R] = in_src_right;
    in_src[EDGE_B] = in_src_bottom;
    in_cut[EDGE_L] = in_cut_left;
    in_cut[EDGE_T] = in_cut_top;
    in_cut[EDGE_R] = in_cut_right;
    in_cut[EDGE_B] = in_cut_bottom;
  end

  assign in_stall = !s1_ready;

  rsp_norm #(.COORD_WIDTH(COORD_WIDTH)) u_norm (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_valid),
    .up_ready (s1_ready),
    .up_src   (in_src),
    .up_cut   (in_cut),
    .dn_valid (s1_valid),
    .dn_ready (s2_ready),
    .dn_src   (s1_src),
    .dn_cut   (s1_cut)
  );

  rsp_classify #(.COORD_WIDTH(COORD_WIDTH)) u_classify (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (s1_valid),
    .up_ready (s2_ready),
    .up_src   (s1_src),
    .up_cut   (s1_cut),
    .dn_valid (s2_valid),
    .dn_ready (s3_ready),
    .dn_src   (s2_src),
    .dn_cut   (s2_cut),
    .dn_flags (s2_flags)
  );

  rsp_pieces #(.COORD_WIDTH(COORD_WIDTH)) u_pieces (
    .clk       (clk),
    .rst_n     (rst_n),
    .up_valid  (s2_valid),
    .up_ready  (s3_ready),
    .up_src    (s2_src),
    .up_cut    (s2_cut),
    .up_flags  (s2_flags),
    .dn_valid  (s3_valid),
    .dn_ready  (ser_ready),
    .dn_pieces (s3_pieces),
    .dn_mask   (s3_mask)
  );

  rsp_serial #(.COORD_WIDTH(COORD_WIDTH)) u_serial (
    .clk       (clk),
    .rst_n     (rst_n),
    .up_valid  (s3_valid),
    .up_ready  (ser_ready),
    .up_pieces (s3_pieces),
    .up_mask   (s3_mask),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_piece (out_piece),
    .out_index (out_piece_index),
    .out_last  (out_piece_last)
  );

  assign out_piece_left   = out_piece[EDGE_L];
  assign out_piece_top    = out_piece[EDGE_T];
  assign out_piece_right  = out_piece[EDGE_R];
  assign out_piece_bottom = out_piece[EDGE_B];

endmodule

`default_nettype wire

[src/rsp_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

module rsp_checker #(
  parameter int unsigned COORD_WIDTH = 16
) (
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic                   out_valid,
  input wire logic                   out_stall,
  input wire logic [COORD_WIDTH-1:0] out_piece_left,
  input wire logic [COORD_WIDTH-1:0] out_piece_top,
  input wire logic [COORD_WIDTH-1:0] out_piece_right,
  input wire logic [COORD_WIDTH-1:0] out_piece_bottom,
  input wire logic [1:0]             out_piece_index,
  input wire logic                   out_piece_last
);

  // A stalled piece holds every field.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_piece_left) &&
      $stable(out_piece_top) && $stable(out_piece_right) &&
      $stable(out_piece_bottom) && $stable(out_piece_index) &&
      $stable(out_piece_last))
    else $error("stalled piece changed");

  // The pieces of one request follow each other without a gap.
  a_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_piece_last |=>
      out_valid && (out_piece_index == $past(out_piece_index) + 2'd1))
    else $error("piece run broken or misnumbered");

  // A fourth piece is always the final one.
  a_four: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_piece_index == 2'd3) |-> out_piece_last)
    else $error("run longer than four pieces");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid straight after reset");

endmodule

bind rect_subtract_pieces_unit rsp_checker #(.COORD_WIDTH(COORD_WIDTH)) u_rsp_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_piece_left   (out_piece_left),
  .out_piece_top    (out_piece_top),
  .out_piece_right  (out_piece_right),
  .out_piece_bottom (out_piece_bottom),
  .out_piece_index  (out_piece_index),
  .out_piece_last   (out_piece_last)
);

`default_nettype wire

[test/tb_rect_subtract_pieces_unit.sv]
`timescale 1ns / 1ps

module tb_rect_subtract_pieces_unit;

  localparam int unsigned CW = rsp_pkg::COORD_WIDTH_DEF;
  localparam int CYCLE_LIMIT = 40000;
  localparam int IDLE_PERCENT = 6;
  localparam int NUM_RANDOM = 90;
  localparam int CALM_FROM = 100;
  localparam int CALM_TO = 260;
  localparam int SETTLE_CYCLES = 20;

  typedef logic signed [CW-1:0] coord_t;

  typedef struct {
    coord_t src_l, src_t, src_r, src_b;
    coord_t cut_l, cut_t, cut_r, cut_b;
    bit     drain;
  } rect_req_t;

  typedef struct {
    coord_t     l, t, r, b;
    logic [1:0] index;
    logic       last;
  } piece_t;

  logic   clk;
  logic   rst_n = 1'b0;
  logic   in_valid = 1'b0;
  logic   in_stall;
  coord_t in_src_left = '0;
  coord_t in_src_top = '0;
  coord_t in_src_right = '0;
  coord_t in_src_bottom = '0;
  coord_t in_cut_left = '0;
  coord_t in_cut_top = '0;
  coord_t in_cut_right = '0;
  coord_t in_cut_bottom = '0;
  logic   out_valid;
  logic   out_stall = 1'b0;
  coord_t out_piece_left;
  coord_t out_piece_top;
  coord_t out_piece_right;
  coord_t out_piece_bottom;
  logic [1:0] out_piece_index;
  logic   out_piece_last;

  rect_req_t pend_q[$];
  piece_t    exp_q[$];
  rect_req_t cur;
  int        errors = 0;
  int        cycle = 0;
  int        quiet = 0;

  rect_subtract_pieces_unit #(.COORD_WIDTH(CW)) i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_src_left      (in_src_left),
    .in_src_top       (in_src_top),
    .in_src_right     (in_src_right),
    .in_src_bottom    (in_src_bottom),
    .in_cut_left      (in_cut_left),
    .in_cut_top       (in_cut_top),
    .in_cut_right     (in_cut_right),
    .in_cut_bottom    (in_cut_bottom),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_piece_left   (out_piece_left),
    .out_piece_top    (out_piece_top),
    .out_piece_right  (out_piece_right),
    .out_piece_bottom (out_piece_bottom),
    .out_piece_index  (out_piece_index),
    .out_piece_last   (out_piece_last)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  task automatic report(input string what);
    errors++;
    $display("MISMATCH cycle %0d: %s", cycle, what);
  endtask

  // Idling is random except for a calm stretch in the middle of the run.
  function automatic bit idle_now();
    if (cycle >= CALM_FROM && cycle < CALM_TO) begin
      return 1'b0;
    end
    return ($urandom_range(0, 99) < IDLE_PERCENT);
  endfunction

  function automatic coord_t rand_coord(input int span);
    int v;
    if (span == 0) begin
      v = int'($urandom());
    end else begin
      v = int'($urandom_range(0, 2 * span)) - span;
    end
    return coord_t'(v);
  endfunction

  function automatic rect_req_t mk_req(input int sl, input int st, input int sr,
                                       input int sb, input int cl, input int ct,
                                       input int cr, input int cb);
    rect_req_t q;
    q.src_l = coord_t'(sl);
    q.src_t = coord_t'(st);
    q.src_r = coord_t'(sr);
    q.src_b = coord_t'(sb);
    q.cut_l = coord_t'(cl);
    q.cut_t = coord_t'(ct);
    q.cut_r = coord_t'(cr);
    q.cut_b = coord_t'(cb);
    q.drain = 1'b0;
    return q;
  endfunction

  function automatic piece_t make_piece(input longint l, input longint t,
                                        input longint r, input longint b,
                                        input int k);
    piece_t p;
    p.l     = coord_t'(l);
    p.t     = coord_t'(t);
    p.r     = coord_t'(r);
    p.b     = coord_t'(b);
    p.index = 2'(k);
    p.last  = 1'b0;
    return p;
  endfunction

  // Expected pieces of one accepted request, appended in emission order.
  function automatic void predict(input rect_req_t q);
    longint sl, st, sr, sb, cl, ct, cr, cb, tmp;
    longint il, it, ir, ib;
    piece_t pcs[$];
    sl = q.src_l;
    st = q.src_t;
    sr = q.src_r;
    sb = q.src_b;
    cl = q.cut_l;
    ct = q.cut_t;
    cr = q.cut_r;
    cb = q.cut_b;
    if (sl > sr) begin tmp = sl; sl = sr; sr = tmp; end
    if (st > sb) begin tmp = st; st = sb; sb = tmp; end
    if (cl > cr) begin tmp = cl; cl = cr; cr = tmp; end
    if (ct > cb) begin tmp = ct; ct = cb; cb = tmp; end
    il = (sl > cl) ? sl : cl;
    it = (st > ct) ? st : ct;
    ir = (sr < cr) ? sr : cr;
    ib = (sb < cb) ? sb : cb;
    if (il > ir || it > ib) begin
      pcs.push_back(make_piece(sl, st, sr, sb, 0));
    end else begin
      if (ct > st) begin
        pcs.push_back(make_piece(sl, st, sr, ct - 1, pcs.size()));
        st = ct;
      end
      if (cb < sb) begin
        pcs.push_back(make_piece(sl, cb + 1, sr, sb, pcs.size()));
        sb = cb;
      end
      if (cl > sl) begin
        pcs.push_back(make_piece(sl, st, cl - 1, sb, pcs.size()));
      end
      if (cr < sr) begin
        pcs.push_back(make_piece(cr + 1, st, sr, sb, pcs.size()));
      end
    end
    if (pcs.size() > 0) begin
      pcs[pcs.size() - 1].last = 1'b1;
    end
    foreach (pcs[k]) begin
      exp_q.push_back(pcs[k]);
    end
  endfunction

  initial begin
    rect_req_t q;
    int span;
    // Corner cases first: every piece, reversed edges, disjoint, covered.
    pend_q.push_back(mk_req(0, 0, 9, 9, 3, 3, 6, 6));
    pend_q.push_back(mk_req(9, 9, 0, 0, 6, 6, 3, 3));
    pend_q.push_back(mk_req(0, 0, 9, 9, 20, 20, 30, 30));
    pend_q.push_back(mk_req(2, 2, 5, 5, 0, 0, 9, 9));
    pend_q.push_back(mk_req(-32768, -32768, 32767, 32767, -32768, -100, 32767, 100));
    pend_q.push_back(mk_req(-32768, -32768, 32767, 32767, -100, -32768, 100, 32767));
    pend_q.push_back(mk_req(-32768, -32768, 32767, 32767, -32768, -32768, 32767, 32767));
    pend_q.push_back(mk_req(-5, -5, 5, 5, 5, -5, 5, 5));
    pend_q.push_back(mk_req(0, 0, 0, 0, 0, 0, 0, 0));
    pend_q.push_back(mk_req(32767, -32768, -32768, 32767, 0, 0, 0, 0));
    for (int k = 0; k < NUM_RANDOM; k++) begin
      case (k % 3)
        0: span = 0;
        1: span = 8;
        default: span = 40;
      endcase
      q.src_l = rand_coord(span);
      q.src_t = rand_coord(span);
      q.src_r = rand_coord(span);
      q.src_b = rand_coord(span);
      q.cut_l = rand_coord(span);
      q.cut_t = rand_coord(span);
      q.cut_r = rand_coord(span);
      q.cut_b = rand_coord(span);
      q.drain = (k == 40) || (k == 75);
      pend_q.push_back(q);
    end
  end

  // Reset, cycle limit and end of run.
  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle == 1) begin
      rst_n <= 1'b1;
    end
    if (rst_n && pend_q.size() == 0 && !in_valid && exp_q.size() == 0) begin
      quiet <= quiet + 1;
    end else begin
      quiet <= 0;
    end
    if (quiet >= SETTLE_CYCLES) begin
      if (errors == 0) begin
        $display("Regression PASS");
      end else begin
        $display("Regression FAIL");
      end
      $finish;
    end
    if (cycle >= CYCLE_LIMIT) begin
      report("cycle limit reached");
      $display("Regression FAIL");
      $finish;
    end
  end

  // Driver: a request waits until it is taken; a drain request first waits
  // for every outstanding piece to come back.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predict(cur);
      end
      if (!in_valid || !in_stall) begin
        if (pend_q.size() > 0 && !idle_now() &&
            !(pend_q[0].drain && exp_q.size() != 0)) begin
          cur = pend_q.pop_front();
          in_valid      <= 1'b1;
          in_src_left   <= cur.src_l;
          in_src_top    <= cur.src_t;
          in_src_right  <= cur.src_r;
          in_src_bottom <= cur.src_b;
          in_cut_left   <= cur.cut_l;
          in_cut_top    <= cur.cut_t;
          in_cut_right  <= cur.cut_r;
          in_cut_bottom <= cur.cut_b;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each accepted piece and stalls the output now and then.
  always @(posedge clk) begin
    piece_t e;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (exp_q.size() == 0) begin
          report($sformatf("unexpected piece %0d %0d %0d %0d",
                           out_piece_left, out_piece_top,
                           out_piece_right, out_piece_bottom));
        end else begin
          e = exp_q.pop_front();
          if (out_piece_left !== e.l || out_piece_top !== e.t ||
              out_piece_right !== e.r || out_piece_bottom !== e.b ||
              out_piece_index !== e.index || out_piece_last !== e.last) begin
            report($sformatf("got %0d %0d %0d %0d i%0d l%0d exp %0d %0d %0d %0d i%0d l%0d",
                             out_piece_left, out_piece_top, out_piece_right,
                             out_piece_bottom, out_piece_index, out_piece_last,
                             e.l, e.t, e.r, e.b, e.index, e.last));
          end
        end
      end
      out_stall <= idle_now();
    end
  end

endmodule

[files.f]
src/rsp_pkg.sv
src/rsp_norm.sv
src/rsp_classify.sv
src/rsp_pieces.sv
src/rsp_serial.sv
src/rect_subtract_pieces_unit.sv
src/rsp_checker.sv
test/tb_rect_subtract_pieces_unit.sv
